### design/e131dmx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e131dmx_pkg
// Shared constants, types, microcode table and header byte table of the
// E1.31 DMX data packet framer.
// ----------------------------------------------------------------------------
package e131dmx_pkg;

  // sizes
  localparam int UNIVERSE_COUNT_DEF = 4;
  localparam int MAX_SLOTS          = 512;
  localparam int ROW_BYTES          = 16;
  localparam int BYTE_W             = $clog2(ROW_BYTES);
  localparam int ROWS_PER_UNI       = MAX_SLOTS / ROW_BYTES;
  localparam int ROW_W              = $clog2(ROWS_PER_UNI);
  localparam int ROW_BITS           = ROW_BYTES * 8;
  localparam int UIDX_W             = 2;
  localparam int SLOT_W             = 9;
  localparam int COUNT_W            = 10;
  localparam int UNI_W              = 16;
  localparam int BEAT_COUNT         = 40;
  localparam int BEAT_W             = 6;
  localparam int PACKET_BYTES       = 638;
  localparam int SLOT_BASE          = 126;
  localparam int SHIFT_BEAT         = SLOT_BASE / ROW_BYTES;
  localparam int MAX_UNIVERSE       = 63999;

  localparam logic [4:0] FULL_BEAT_BYTES = 5'(ROW_BYTES);
  localparam logic [4:0] LAST_BEAT_BYTES = 5'(PACKET_BYTES - ROW_BYTES * (BEAT_COUNT - 1));

  // flag and length words
  localparam logic [15:0] FLAG_BITS     = 16'h7000;
  localparam logic [15:0] ROOT_LEN_ADD  = 16'd110;
  localparam logic [15:0] FRAME_LEN_ADD = 16'd88;
  localparam logic [15:0] DMP_LEN_ADD   = 16'd11;
  localparam logic [15:0] PROP_CNT_ADD  = 16'd1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_UNI = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS    = 1'd1;
  localparam logic [UNI_W-1:0]     BASE_UNI_RST = 16'd1;
  localparam logic [COUNT_W-1:0]   SLOTS_RST    = 10'd512;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_SEND  = 1'b1;

  // microcode steps
  localparam int STEP_W = 2;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 2'd0;
  localparam logic [STEP_W-1:0] STEP_PRIME = 2'd1;
  localparam logic [STEP_W-1:0] STEP_BEAT  = 2'd2;
  localparam logic [STEP_W-1:0] STEP_DONE  = 2'd3;

  // jump conditions
  localparam logic [1:0] JC_NEXT = 2'd0;
  localparam logic [1:0] JC_SEND = 2'd1;
  localparam logic [1:0] JC_LAST = 2'd2;
  localparam logic [1:0] JC_JUMP = 2'd3;

  typedef struct packed {
    logic              in_rdy;
    logic              emit;
    logic              finish;
    logic [1:0]        jc;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_rdy;
    logic emit;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic send_fire;
    logic last_load;
  } stat_t;

  typedef struct packed {
    logic [15:0] len_root;
    logic [15:0] len_frame;
    logic [15:0] len_dmp;
    logic [15:0] prop_cnt;
    logic [15:0] uni;
    logic [7:0]  seq;
  } hdr_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    case (step)
      STEP_IDLE: begin
        w.in_rdy = 1'b1;
        w.jc     = JC_SEND;
        w.target = STEP_PRIME;
      end
      STEP_PRIME: begin
        w.jc = JC_NEXT;
      end
      STEP_BEAT: begin
        w.emit = 1'b1;
        w.jc   = JC_LAST;
      end
      STEP_DONE: begin
        w.finish = 1'b1;
        w.jc     = JC_JUMP;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jc     = JC_JUMP;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // header bytes 0 to 125
  function automatic logic [7:0] hdr_byte(input logic [6:0] pos, input hdr_t h);
    logic [7:0] b;
    b = 8'h00;
    case (pos)
      7'd1:   b = 8'h10;
      7'd4:   b = 8'h41;
      7'd5:   b = 8'h53;
      7'd6:   b = 8'h43;
      7'd7:   b = 8'h2d;
      7'd8:   b = 8'h45;
      7'd9:   b = 8'h31;
      7'd10:  b = 8'h2e;
      7'd11:  b = 8'h31;
      7'd12:  b = 8'h37;
      7'd16:  b = h.len_root[15:8];
      7'd17:  b = h.len_root[7:0];
      7'd21:  b = 8'h04;
      7'd38:  b = h.len_frame[15:8];
      7'd39:  b = h.len_frame[7:0];
      7'd43:  b = 8'h02;
      // sender tag
      7'd44:  b = 8'h6c;
      7'd45:  b = 8'h69;
      7'd46:  b = 8'h62;
      7'd47:  b = 8'h6f;
      7'd48:  b = 8'h73;
      7'd49:  b = 8'h73;
      7'd50:  b = 8'h69;
      7'd51:  b = 8'h61;
      7'd108: b = 8'h64;
      7'd111: b = h.seq;
      7'd113: b = h.uni[15:8];
      7'd114: b = h.uni[7:0];
      7'd115: b = h.len_dmp[15:8];
      7'd116: b = h.len_dmp[7:0];
      7'd117: b = 8'h02;
      7'd118: b = 8'ha1;
      7'd122: b = 8'h01;
      7'd123: b = h.prop_cnt[15:8];
      7'd124: b = h.prop_cnt[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

### design/e131dmx_slot_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e131dmx_slot_mem
// Slot level store, one 16-byte row per address, byte write, registered read,
// zero-clearing pass after reset.
// ----------------------------------------------------------------------------
module e131dmx_slot_mem #(
  parameter int UNIVERSE_COUNT = e131dmx_pkg::UNIVERSE_COUNT_DEF,
  parameter int ADDR_W         = $clog2(UNIVERSE_COUNT * e131dmx_pkg::ROWS_PER_UNI)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  wr_en,
  input  wire logic [ADDR_W-1:0]                     wr_addr,
  input  wire logic [e131dmx_pkg::BYTE_W-1:0]        wr_byte,
  input  wire logic [7:0]                            wr_data,
  input  wire logic [ADDR_W-1:0]                     rd_addr,
  output logic      [e131dmx_pkg::ROW_BITS-1:0]      rd_data,
  output logic                                       busy
);

  localparam int DEPTH = UNIVERSE_COUNT * e131dmx_pkg::ROWS_PER_UNI;

  logic [e131dmx_pkg::ROW_BITS-1:0] mem [DEPTH];
  logic              clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr][{wr_byte, 3'b000} +: 8] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign busy = clr_busy_r;

endmodule
`default_nettype wire

### design/e131dmx_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e131dmx_seq
// Microcode sequencer: step counter, control word table and jump logic.
// ----------------------------------------------------------------------------
module e131dmx_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire e131dmx_pkg::stat_t  stat,
  output e131dmx_pkg::ctl_t        ctl
);

  logic [e131dmx_pkg::STEP_W-1:0] step_r, step_nxt;
  e131dmx_pkg::ucode_t            uc;

  assign uc = e131dmx_pkg::ucode_rom(step_r);

  always_comb begin
    step_nxt = step_r;
    case (uc.jc)
      e131dmx_pkg::JC_NEXT: step_nxt = step_r + 1'b1;
      e131dmx_pkg::JC_SEND: if (stat.send_fire) step_nxt = uc.target;
      e131dmx_pkg::JC_LAST: if (stat.last_load) step_nxt = step_r + 1'b1;
      e131dmx_pkg::JC_JUMP: step_nxt = uc.target;
      default:              step_nxt = e131dmx_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= e131dmx_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctl.in_rdy = uc.in_rdy;
  assign ctl.emit   = uc.emit;
  assign ctl.finish = uc.finish;

endmodule
`default_nettype wire

### design/e131dmx_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e131dmx_datapath
// Item decode, dirty marks, sequence count, packet header fields, beat
// assembly from header table and slot rows, and the output register.
// ----------------------------------------------------------------------------
module e131dmx_datapath #(
  parameter int UNIVERSE_COUNT = e131dmx_pkg::UNIVERSE_COUNT_DEF,
  parameter int ADDR_W         = $clog2(UNIVERSE_COUNT * e131dmx_pkg::ROWS_PER_UNI)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire e131dmx_pkg::ctl_t                    ctl,
  output e131dmx_pkg::stat_t                        stat,
  input  wire logic                                 in_fire,
  input  wire logic                                 in_mode,
  input  wire logic [e131dmx_pkg::UIDX_W-1:0]       in_universe_index,
  input  wire logic [e131dmx_pkg::SLOT_W-1:0]       in_slot_index,
  input  wire logic [7:0]                           in_slot_value,
  input  wire logic [e131dmx_pkg::UNI_W-1:0]        base_uni,
  input  wire logic [e131dmx_pkg::COUNT_W-1:0]      slots_per_universe,
  output logic                                      wr_en,
  output logic      [ADDR_W-1:0]                    wr_addr,
  output logic      [e131dmx_pkg::BYTE_W-1:0]       wr_byte,
  output logic      [7:0]                           wr_data,
  output logic      [ADDR_W-1:0]                    rd_addr,
  input  wire logic [e131dmx_pkg::ROW_BITS-1:0]     rd_data,
  input  wire logic                                 out_ready,
  output logic                                      out_valid,
  output logic      [63:0]                          out_beat_high,
  output logic      [63:0]                          out_beat_low,
  output logic      [4:0]                           out_valid_bytes,
  output logic                                      out_last_beat
);

  localparam int RB = e131dmx_pkg::ROW_BITS;

  // item decode
  logic        u_ok, dirty_hit, uni_ok, n_ok, is_write;
  logic [16:0] uni_sum;

  // packet state
  logic [e131dmx_pkg::UIDX_W-1:0]  uidx_r, uidx_nxt;
  logic [e131dmx_pkg::COUNT_W-1:0] n_r, n_nxt;
  e131dmx_pkg::hdr_t               hdr_r, hdr_nxt;
  logic [e131dmx_pkg::BEAT_W-1:0]  beat_r, beat_nxt;
  logic [e131dmx_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [RB-1:0]                   prev_r, prev_nxt;
  logic [7:0]                      seq_r, seq_nxt;
  logic [UNIVERSE_COUNT-1:0]       dirty_r, dirty_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [RB-1:0] beat_data_r;
  logic [4:0]    vbytes_r;
  logic          last_r;
  logic          out_space, load, beat_last, shift;
  logic [RB-1:0] beat_data;

  assign u_ok    = 32'(in_universe_index) < UNIVERSE_COUNT;
  assign uni_sum = 17'(base_uni) + 17'(in_universe_index);
  assign uni_ok  = (uni_sum != 17'd0) && (uni_sum <= 17'(e131dmx_pkg::MAX_UNIVERSE));
  assign n_ok    = (slots_per_universe != '0) &&
                   (slots_per_universe <= e131dmx_pkg::COUNT_W'(e131dmx_pkg::MAX_SLOTS));

  always_comb begin
    dirty_hit = 1'b0;
    for (int i = 0; i < UNIVERSE_COUNT; i++) begin
      if (32'(in_universe_index) == i) begin
        dirty_hit = dirty_r[i];
      end
    end
  end

  assign is_write       = in_fire && u_ok && (in_mode == e131dmx_pkg::MODE_WRITE);
  assign stat.send_fire = in_fire && u_ok && (in_mode == e131dmx_pkg::MODE_SEND) &&
                          dirty_hit && uni_ok && n_ok;

  // slot write goes straight to the store
  assign wr_en   = is_write;
  assign wr_addr = ADDR_W'({in_universe_index,
                            in_slot_index[e131dmx_pkg::BYTE_W +: e131dmx_pkg::ROW_W]});
  assign wr_byte = in_slot_index[e131dmx_pkg::BYTE_W-1:0];
  assign wr_data = in_slot_value;

  assign out_space = !out_valid_r || out_ready;
  assign load      = ctl.emit && out_space;
  assign beat_last = beat_r == e131dmx_pkg::BEAT_W'(e131dmx_pkg::BEAT_COUNT - 1);
  assign shift     = load && (beat_r >= e131dmx_pkg::BEAT_W'(e131dmx_pkg::SHIFT_BEAT));
  assign stat.last_load = load && beat_last;

  always_comb begin
    uidx_nxt  = uidx_r;
    n_nxt     = n_r;
    hdr_nxt   = hdr_r;
    beat_nxt  = beat_r;
    row_nxt   = row_r;
    prev_nxt  = prev_r;
    seq_nxt   = seq_r;
    dirty_nxt = dirty_r;
    if (stat.send_fire) begin
      uidx_nxt           = in_universe_index;
      n_nxt              = slots_per_universe;
      hdr_nxt.len_root   = e131dmx_pkg::FLAG_BITS |
                           (16'(slots_per_universe) + e131dmx_pkg::ROOT_LEN_ADD);
      hdr_nxt.len_frame  = e131dmx_pkg::FLAG_BITS |
                           (16'(slots_per_universe) + e131dmx_pkg::FRAME_LEN_ADD);
      hdr_nxt.len_dmp    = e131dmx_pkg::FLAG_BITS |
                           (16'(slots_per_universe) + e131dmx_pkg::DMP_LEN_ADD);
      hdr_nxt.prop_cnt   = 16'(slots_per_universe) + e131dmx_pkg::PROP_CNT_ADD;
      hdr_nxt.uni        = uni_sum[15:0];
      hdr_nxt.seq        = seq_r;
      beat_nxt           = '0;
      row_nxt            = '0;
    end
    if (load) begin
      beat_nxt = beat_r + 1'b1;
    end
    if (shift) begin
      prev_nxt = rd_data;
      row_nxt  = row_r + 1'b1;
    end
    if (ctl.finish) begin
      seq_nxt = seq_r + 8'd1;
    end
    for (int i = 0; i < UNIVERSE_COUNT; i++) begin
      if (is_write && (32'(in_universe_index) == i)) begin
        dirty_nxt[i] = 1'b1;
      end
      if (ctl.finish && (32'(uidx_r) == i)) begin
        dirty_nxt[i] = 1'b0;
      end
    end
  end

  // read address follows the next row, so the row read is registered and ready in the next cycle
  assign rd_addr = ADDR_W'({uidx_nxt, row_nxt});

  // beat assembly, byte b of the beat lands in the top bits first
  for (genvar b = 0; b < e131dmx_pkg::ROW_BYTES; b++) begin : g_byte
    logic [9:0] pos;
    logic [9:0] slot_j;
    logic [7:0] slot_byte;
    logic [7:0] byte_val;

    assign pos    = {beat_r, 4'(b)};
    assign slot_j = pos - 10'(e131dmx_pkg::SLOT_BASE);

    if (b < e131dmx_pkg::ROW_BYTES - 2) begin : g_prev
      assign slot_byte = prev_r[8*(b+2) +: 8];
    end else begin : g_cur
      assign slot_byte = rd_data[8*(b-(e131dmx_pkg::ROW_BYTES-2)) +: 8];
    end

    always_comb begin
      if (pos < 10'(e131dmx_pkg::SLOT_BASE)) begin
        byte_val = e131dmx_pkg::hdr_byte(pos[6:0], hdr_r);
      end else if (slot_j < n_r) begin
        byte_val = slot_byte;
      end else begin
        byte_val = 8'h00;
      end
    end

    assign beat_data[RB-1-8*b -: 8] = byte_val;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= '0;
      dirty_r     <= '0;
      beat_r      <= '0;
      row_r       <= '0;
      uidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      dirty_r     <= dirty_nxt;
      beat_r      <= beat_nxt;
      row_r       <= row_nxt;
      uidx_r      <= uidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    hdr_r  <= hdr_nxt;
    prev_r <= prev_nxt;
    if (load) begin
      beat_data_r <= beat_data;
      vbytes_r    <= beat_last ? e131dmx_pkg::LAST_BEAT_BYTES : e131dmx_pkg::FULL_BEAT_BYTES;
      last_r      <= beat_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_beat_high   = beat_data_r[RB-1 -: 64];
  assign out_beat_low    = beat_data_r[63:0];
  assign out_valid_bytes = vbytes_r;
  assign out_last_beat   = last_r;

endmodule
`default_nettype wire

### design/e131_dmx_packet_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e131_dmx_packet_framer
// E1.31 DMX data packet framer: slot store per universe, dirty tracking and
// 638-byte packet streaming in 16-byte beats under a microcoded sequencer.
// ----------------------------------------------------------------------------
// A write item (mode 0) stores one slot level and marks its universe dirty. A
// send item (mode 1) for a dirty universe streams one 638-byte data packet as
// 40 beats of 16 bytes, first byte in the top bits of out_beat_high, 14 valid
// bytes in the last beat. A send passes from the accept step through a prime
// step for the slot store read, the beat step for the 40 beats, a wrap-up
// step and back to the accept step; the pace is set by the single read port of
// the slot store, which yields one 16-byte row per beat. A send for a clean
// universe, or with a universe number outside 1..63999 or a slot count outside
// 1..512, is consumed and produces nothing. After reset the slot store is
// zeroed by a clearing pass over all UNIVERSE_COUNT*32 rows (128 by default)
// while in_ready stays low; configuration writes are taken during the pass.
// The user must write the configuration registers only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module e131_dmx_packet_framer #(
  parameter int UNIVERSE_COUNT = e131dmx_pkg::UNIVERSE_COUNT_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // item channel
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_mode,
  input  wire logic [e131dmx_pkg::UIDX_W-1:0]        in_universe_index,
  input  wire logic [e131dmx_pkg::SLOT_W-1:0]        in_slot_index,
  input  wire logic [7:0]                            in_slot_value,
  // beat channel
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic      [63:0]                           out_beat_high,
  output logic      [63:0]                           out_beat_low,
  output logic      [4:0]                            out_valid_bytes,
  output logic                                       out_last_beat,
  // configuration writes
  input  wire logic                                  cfg_wr_en,
  input  wire logic [e131dmx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [e131dmx_pkg::UNI_W-1:0]         cfg_wdata
);

  localparam int ADDR_W = $clog2(UNIVERSE_COUNT * e131dmx_pkg::ROWS_PER_UNI);

  // configuration registers
  logic [e131dmx_pkg::UNI_W-1:0]   base_uni_r, base_uni_nxt;
  logic [e131dmx_pkg::COUNT_W-1:0] slots_r, slots_nxt;

  // sequencer handshake
  e131dmx_pkg::ctl_t  ctl;
  e131dmx_pkg::stat_t stat;
  logic               in_fire;

  // slot store ports
  logic                             mem_wr_en;
  logic [ADDR_W-1:0]                mem_wr_addr;
  logic [e131dmx_pkg::BYTE_W-1:0]   mem_wr_byte;
  logic [7:0]                       mem_wr_data;
  logic [ADDR_W-1:0]                mem_rd_addr;
  logic [e131dmx_pkg::ROW_BITS-1:0] mem_rd_data;
  logic                             mem_busy;

  always_comb begin
    base_uni_nxt = base_uni_r;
    slots_nxt    = slots_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        e131dmx_pkg::CFG_BASE_UNI: base_uni_nxt = cfg_wdata;
        e131dmx_pkg::CFG_SLOTS:    slots_nxt = cfg_wdata[e131dmx_pkg::COUNT_W-1:0];
        default: begin
          base_uni_nxt = base_uni_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_uni_r <= e131dmx_pkg::BASE_UNI_RST;
      slots_r    <= e131dmx_pkg::SLOTS_RST;
    end else begin
      base_uni_r <= base_uni_nxt;
      slots_r    <= slots_nxt;
    end
  end

  // items are taken only in the accept step and never during the clearing pass
  assign in_ready = ctl.in_rdy && !mem_busy;
  assign in_fire  = in_valid && in_ready;

  e131dmx_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  e131dmx_datapath #(
    .UNIVERSE_COUNT (UNIVERSE_COUNT),
    .ADDR_W         (ADDR_W)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .stat               (stat),
    .in_fire            (in_fire),
    .in_mode            (in_mode),
    .in_universe_index  (in_universe_index),
    .in_slot_index      (in_slot_index),
    .in_slot_value      (in_slot_value),
    .base_uni           (base_uni_r),
    .slots_per_universe (slots_r),
    .wr_en              (mem_wr_en),
    .wr_addr            (mem_wr_addr),
    .wr_byte            (mem_wr_byte),
    .wr_data            (mem_wr_data),
    .rd_addr            (mem_rd_addr),
    .rd_data            (mem_rd_data),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_beat_high      (out_beat_high),
    .out_beat_low       (out_beat_low),
    .out_valid_bytes    (out_valid_bytes),
    .out_last_beat      (out_last_beat)
  );

  e131dmx_slot_mem #(
    .UNIVERSE_COUNT (UNIVERSE_COUNT),
    .ADDR_W         (ADDR_W)
  ) u_slot_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_byte (mem_wr_byte),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .busy    (mem_busy)
  );

  // no item is taken while the store is being cleared
  a_busy_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> !in_ready)
    else $error("item channel ready during clearing pass");

  // nothing can be streamed before the store is clean
  a_busy_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> !out_valid)
    else $error("beat shown during clearing pass");

  // the two bytes past the end of the packet are padding
  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_beat) |-> (out_beat_low[15:0] == 16'h0000))
    else $error("final beat tail not zero");

  // no item is taken while a packet is being streamed
  a_emit_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> !in_ready)
    else $error("item channel ready during packet streaming");

endmodule
`default_nettype wire
